/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* src/orsm_pkg.sv */
package orsm_pkg;

   // Default array limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Field widths
   localparam int COORD_W = 10;
   localparam int DIM_W   = 11;
   localparam int ROW_W   = 1 + 2 * COORD_W;

   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   // Register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_CLOSE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_START = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FINAL,
      S_STEP,
      S_MARK_RD,
      S_MARK_WR,
      S_QUERY,
      S_REPLY
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic step;
      logic load_final;
      logic mark_rd;
      logic mark_wr;
      logic query_rd;
      logic reply_load;
      logic close_done;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      func_type op;
      logic     closed;
      logic     have_point;
      logic     far;
      logic     final_mark;
      logic     clear_last;
      logic     out_free;
   } status_type;

   // Register value saturated into 1..maxv
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > maxv) begin
         r = DIM_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Coordinate clamped to dimension minus one
   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c,
                                                      input logic [DIM_W-1:0] dim);
      logic [DIM_W-1:0]   lim;
      logic [COORD_W-1:0] r;
      lim = dim - DIM_W'(1);
      if ({1'b0, c} > lim) begin
         r = lim[COORD_W-1:0];
      end else begin
         r = c;
      end
      return r;
   endfunction

   // One pixel toward the target
   function automatic logic [COORD_W-1:0] step_toward(input logic [COORD_W-1:0] from,
                                                      input logic [COORD_W-1:0] to);
      logic [COORD_W-1:0] r;
      if (to > from) begin
         r = from + COORD_W'(1);
      end else if (to < from) begin
         r = from - COORD_W'(1);
      end else begin
         r = from;
      end
      return r;
   endfunction

   // More than one pixel apart on this axis
   function automatic logic far_apart(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
      return ({1'b0, b} > ({1'b0, a} + DIM_W'(1))) || ({1'b0, a} > ({1'b0, b} + DIM_W'(1)));
   endfunction

endpackage

/* src/outline_row_span_mask.sv */
// Outline row-span mask. Requests add a point (clamped into the image), close
// the outline, read one row's span, or start a new outline. A read gives one
// response; the other requests give none. Points more than one pixel apart are
// joined by 8-connected steps, and every outline pixel costs one read-modify-
// write of the per-row span memory (step, read, write). A read waits for the
// response register to be free. After reset and after each start the span
// memory is cleared one row per cycle, during which req_ready is low; register
// writes are taken at any time but should only be made while the block is
// idle.
module outline_row_span_mask #(
   parameter int MAX_WIDTH  = orsm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = orsm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [orsm_pkg::COORD_W-1:0] req_x,
   input  logic [orsm_pkg::COORD_W-1:0] req_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_row_covered,
   output logic [orsm_pkg::COORD_W-1:0] rsp_span_left,
   output logic [orsm_pkg::COORD_W-1:0] rsp_span_right,
   output logic [orsm_pkg::DIM_W-1:0]   rsp_box_min_x,
   output logic [orsm_pkg::DIM_W-1:0]   rsp_box_min_y,
   output logic [orsm_pkg::COORD_W-1:0] rsp_box_max_x,
   output logic [orsm_pkg::COORD_W-1:0] rsp_box_max_y,
   output logic                         rsp_outline_closed,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [orsm_pkg::DIM_W-1:0]   csr_wr_data
);

   orsm_pkg::cmd_type    cmd;
   orsm_pkg::status_type status;
   orsm_pkg::func_type   req_op;

   assign req_op = orsm_pkg::func_type'(req_func);

   orsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .req_op    (req_op),
      .cmd       (cmd)
   );

   orsm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_x              (req_x),
      .req_y              (req_y),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_row_covered    (rsp_row_covered),
      .rsp_span_left      (rsp_span_left),
      .rsp_span_right     (rsp_span_right),
      .rsp_box_min_x      (rsp_box_min_x),
      .rsp_box_min_y      (rsp_box_min_y),
      .rsp_box_max_x      (rsp_box_max_x),
      .rsp_box_max_y      (rsp_box_max_y),
      .rsp_outline_closed (rsp_outline_closed)
   );

endmodule

/* src/orsm_ram.sv */
module orsm_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/orsm_ctrl.sv */
module orsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  orsm_pkg::status_type status,
   input  orsm_pkg::func_type  req_op,
   output orsm_pkg::cmd_type   cmd
);

   orsm_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_ready = (state_ff == orsm_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= orsm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         orsm_pkg::S_CLEAR: begin
            if (status.clear_last) state_in = orsm_pkg::S_IDLE;
         end
         orsm_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  orsm_pkg::FUNC_ADD: begin
                     if (status.closed) state_in = orsm_pkg::S_IDLE;
                     else if (!status.have_point) state_in = orsm_pkg::S_FINAL;
                     else state_in = orsm_pkg::S_STEP;
                  end
                  orsm_pkg::FUNC_CLOSE: begin
                     if (!status.have_point || status.closed) state_in = orsm_pkg::S_IDLE;
                     else state_in = orsm_pkg::S_STEP;
                  end
                  orsm_pkg::FUNC_READ:  state_in = orsm_pkg::S_QUERY;
                  orsm_pkg::FUNC_START: state_in = orsm_pkg::S_CLEAR;
                  default:              state_in = orsm_pkg::S_IDLE;
               endcase
            end
         end
         orsm_pkg::S_FINAL:   state_in = orsm_pkg::S_MARK_RD;
         orsm_pkg::S_STEP: begin
            if (status.far) state_in = orsm_pkg::S_MARK_RD;
            else if (status.op == orsm_pkg::FUNC_CLOSE) state_in = orsm_pkg::S_IDLE;
            else state_in = orsm_pkg::S_MARK_RD;
         end
         orsm_pkg::S_MARK_RD: state_in = orsm_pkg::S_MARK_WR;
         orsm_pkg::S_MARK_WR: begin
            if (status.final_mark) state_in = orsm_pkg::S_IDLE;
            else state_in = orsm_pkg::S_STEP;
         end
         orsm_pkg::S_QUERY:   state_in = orsm_pkg::S_REPLY;
         orsm_pkg::S_REPLY: begin
            if (status.out_free) state_in = orsm_pkg::S_IDLE;
         end
         default: state_in = orsm_pkg::S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      cmd.accept = accept;
      unique case (state_ff)
         orsm_pkg::S_CLEAR:   cmd.clear_wr = 1'b1;
         orsm_pkg::S_IDLE:    ;
         orsm_pkg::S_FINAL:   cmd.load_final = 1'b1;
         orsm_pkg::S_STEP: begin
            if (status.far) cmd.step = 1'b1;
            else if (status.op == orsm_pkg::FUNC_CLOSE) cmd.close_done = 1'b1;
            else cmd.load_final = 1'b1;
         end
         orsm_pkg::S_MARK_RD: cmd.mark_rd = 1'b1;
         orsm_pkg::S_MARK_WR: cmd.mark_wr = 1'b1;
         orsm_pkg::S_QUERY:   cmd.query_rd = 1'b1;
         orsm_pkg::S_REPLY:   cmd.reply_load = status.out_free;
         default:             ;
      endcase
   end

endmodule

/* src/orsm_datapath.sv */
module orsm_datapath #(
   parameter int MAX_WIDTH  = orsm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = orsm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  orsm_pkg::cmd_type                    cmd,
   output orsm_pkg::status_type                 status,
   input  orsm_pkg::func_type                   req_op,
   input  logic [orsm_pkg::COORD_W-1:0]         req_x,
   input  logic [orsm_pkg::COORD_W-1:0]         req_y,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_index,
   input  logic [orsm_pkg::DIM_W-1:0]           csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_row_covered,
   output logic [orsm_pkg::COORD_W-1:0]         rsp_span_left,
   output logic [orsm_pkg::COORD_W-1:0]         rsp_span_right,
   output logic [orsm_pkg::DIM_W-1:0]           rsp_box_min_x,
   output logic [orsm_pkg::DIM_W-1:0]           rsp_box_min_y,
   output logic [orsm_pkg::COORD_W-1:0]         rsp_box_max_x,
   output logic [orsm_pkg::COORD_W-1:0]         rsp_box_max_y,
   output logic                                 rsp_outline_closed
);

   localparam int CW     = orsm_pkg::COORD_W;
   localparam int DW     = orsm_pkg::DIM_W;
   localparam int RW     = orsm_pkg::ROW_W;
   localparam int AW     = $clog2(MAX_HEIGHT);
   localparam int YW     = (AW > CW) ? AW : CW;
   localparam logic [AW-1:0] LAST_ROW = AW'(MAX_HEIGHT - 1);

   // Configuration
   logic [DW-1:0] img_w_ff, img_h_ff;
   logic [DW-1:0] eff_w, eff_h;

   // Outline state
   logic [CW-1:0] last_x_ff, last_y_ff, first_x_ff, first_y_ff;
   logic [DW-1:0] min_col_ff, min_row_ff;
   logic [CW-1:0] max_col_ff, max_row_ff;
   logic          have_ff, closed_ff, final_ff;
   orsm_pkg::func_type op_ff;

   // Working registers
   logic [CW-1:0] tgt_x_ff, tgt_y_ff, pix_x_ff, pix_y_ff;
   logic          row_ok_ff;
   logic [AW-1:0] clr_cnt_ff;

   // Result register
   logic          rsp_valid_ff, cov_ff, closed_out_ff;
   logic [CW-1:0] left_out_ff, right_out_ff, max_x_out_ff, max_y_out_ff;
   logic [DW-1:0] min_x_out_ff, min_y_out_ff;

   logic [CW-1:0] clamp_x, clamp_y, next_x, next_y;
   logic [YW-1:0] pix_y_wide, tgt_y_wide;
   logic [AW-1:0] pix_row, tgt_row;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [RW-1:0] ram_wr_data, ram_rd_data, marked_row;
   logic          rd_seen;
   logic [CW-1:0] rd_left, rd_right;
   logic          out_free, cov;

   assign eff_w   = orsm_pkg::eff_dim(img_w_ff, MAX_WIDTH);
   assign eff_h   = orsm_pkg::eff_dim(img_h_ff, MAX_HEIGHT);
   assign clamp_x = orsm_pkg::clamp_coord(req_x, eff_w);
   assign clamp_y = orsm_pkg::clamp_coord(req_y, eff_h);
   assign next_x  = orsm_pkg::step_toward(last_x_ff, tgt_x_ff);
   assign next_y  = orsm_pkg::step_toward(last_y_ff, tgt_y_ff);

   assign pix_y_wide = YW'(pix_y_ff);
   assign tgt_y_wide = YW'(tgt_y_ff);
   assign pix_row    = pix_y_wide[AW-1:0];
   assign tgt_row    = tgt_y_wide[AW-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Status back to the controller
   always_comb begin
      status.op         = op_ff;
      status.closed     = closed_ff;
      status.have_point = have_ff;
      status.far        = orsm_pkg::far_apart(last_x_ff, tgt_x_ff)
                          || orsm_pkg::far_apart(last_y_ff, tgt_y_ff);
      status.final_mark = final_ff;
      status.clear_last = (clr_cnt_ff == LAST_ROW);
      status.out_free   = out_free;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= orsm_pkg::DIM_RESET;
         img_h_ff <= orsm_pkg::DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            orsm_pkg::CSR_IMAGE_WIDTH:  img_w_ff <= csr_wr_data;
            orsm_pkg::CSR_IMAGE_HEIGHT: img_h_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Row store: {seen, left, right} per row
   assign rd_seen  = ram_rd_data[RW-1];
   assign rd_left  = ram_rd_data[2*CW-1:CW];
   assign rd_right = ram_rd_data[CW-1:0];

   always_comb begin
      if (!rd_seen) begin
         marked_row = {1'b1, pix_x_ff, pix_x_ff};
      end else if (pix_x_ff < rd_left) begin
         marked_row = {1'b1, pix_x_ff, rd_right};
      end else if (pix_x_ff > rd_right) begin
         marked_row = {1'b1, rd_left, pix_x_ff};
      end else begin
         marked_row = ram_rd_data;
      end
   end

   always_comb begin
      ram_wr_en   = cmd.clear_wr || cmd.mark_wr;
      ram_wr_addr = cmd.clear_wr ? clr_cnt_ff : pix_row;
      ram_wr_data = cmd.clear_wr ? '0 : marked_row;
      ram_rd_en   = cmd.mark_rd || cmd.query_rd;
      ram_rd_addr = cmd.query_rd ? tgt_row : pix_row;
   end

   orsm_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_HEIGHT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Outline control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         min_col_ff <= orsm_pkg::eff_dim(orsm_pkg::DIM_RESET, MAX_WIDTH);
         min_row_ff <= orsm_pkg::eff_dim(orsm_pkg::DIM_RESET, MAX_HEIGHT);
         max_col_ff <= '0;
         max_row_ff <= '0;
         have_ff    <= 1'b0;
         closed_ff  <= 1'b0;
         final_ff   <= 1'b0;
         op_ff      <= orsm_pkg::FUNC_ADD;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.accept) begin
            op_ff <= req_op;
            case (req_op)
               orsm_pkg::FUNC_ADD: begin
                  if (!closed_ff && !have_ff) begin
                     first_x_ff <= clamp_x;
                     first_y_ff <= clamp_y;
                     have_ff    <= 1'b1;
                  end
               end
               orsm_pkg::FUNC_START: begin
                  last_x_ff  <= '0;
                  last_y_ff  <= '0;
                  first_x_ff <= '0;
                  first_y_ff <= '0;
                  min_col_ff <= eff_w;
                  min_row_ff <= eff_h;
                  max_col_ff <= '0;
                  max_row_ff <= '0;
                  have_ff    <= 1'b0;
                  closed_ff  <= 1'b0;
                  clr_cnt_ff <= '0;
               end
               default: ;
            endcase
         end
         if (cmd.step) begin
            last_x_ff <= next_x;
            last_y_ff <= next_y;
            final_ff  <= 1'b0;
         end
         if (cmd.load_final) begin
            last_x_ff <= tgt_x_ff;
            last_y_ff <= tgt_y_ff;
            final_ff  <= 1'b1;
         end
         if (cmd.close_done) begin
            last_x_ff <= first_x_ff;
            last_y_ff <= first_y_ff;
            closed_ff <= 1'b1;
         end
         // Bounding box follows every marked pixel
         if (cmd.mark_wr) begin
            if ({1'b0, pix_x_ff} < min_col_ff) min_col_ff <= {1'b0, pix_x_ff};
            if (pix_x_ff > max_col_ff)         max_col_ff <= pix_x_ff;
            if ({1'b0, pix_y_ff} < min_row_ff) min_row_ff <= {1'b0, pix_y_ff};
            if (pix_y_ff > max_row_ff)         max_row_ff <= pix_y_ff;
         end
      end
   end

   // Target and pixel registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         case (req_op)
            orsm_pkg::FUNC_ADD: begin
               tgt_x_ff <= clamp_x;
               tgt_y_ff <= clamp_y;
            end
            orsm_pkg::FUNC_CLOSE: begin
               tgt_x_ff <= first_x_ff;
               tgt_y_ff <= first_y_ff;
            end
            orsm_pkg::FUNC_READ: begin
               tgt_y_ff  <= req_y;
               row_ok_ff <= (int'(req_y) < MAX_HEIGHT);
            end
            default: ;
         endcase
      end
      if (cmd.step) begin
         pix_x_ff <= next_x;
         pix_y_ff <= next_y;
      end
      if (cmd.load_final) begin
         pix_x_ff <= tgt_x_ff;
         pix_y_ff <= tgt_y_ff;
      end
   end

   // Result register
   assign cov = row_ok_ff && rd_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply_load) begin
         cov_ff        <= cov;
         left_out_ff   <= cov ? rd_left : '0;
         right_out_ff  <= cov ? rd_right : '0;
         min_x_out_ff  <= min_col_ff;
         min_y_out_ff  <= min_row_ff;
         max_x_out_ff  <= max_col_ff;
         max_y_out_ff  <= max_row_ff;
         closed_out_ff <= closed_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_covered    = cov_ff;
   assign rsp_span_left      = left_out_ff;
   assign rsp_span_right     = right_out_ff;
   assign rsp_box_min_x      = min_x_out_ff;
   assign rsp_box_min_y      = min_y_out_ff;
   assign rsp_box_max_x      = max_x_out_ff;
   assign rsp_box_max_y      = max_y_out_ff;
   assign rsp_outline_closed = closed_out_ff;

endmodule

/* src/orsm_checker.sv */
`include "assert_macros.svh"

module orsm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_row_covered,
   input logic [orsm_pkg::COORD_W-1:0] rsp_span_left,
   input logic [orsm_pkg::COORD_W-1:0] rsp_span_right,
   input logic [orsm_pkg::DIM_W-1:0]   rsp_box_min_x,
   input logic [orsm_pkg::COORD_W-1:0] rsp_box_max_x
);

   // A stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_span_left) && $stable(rsp_span_right) && $stable(rsp_row_covered))

   // Memory clear runs straight after reset, so no request is taken
   `ASSERT_IMPLIES(a_clear_after_reset, clock, reset, $past(reset), !req_ready && !rsp_valid)

   // Uncovered row reports an empty span
   `ASSERT_IMPLIES(a_uncovered_zero, clock, reset, rsp_valid && !rsp_row_covered, rsp_span_left == '0 && rsp_span_right == '0)

   // Covered row has an ordered span
   `ASSERT_IMPLIES(a_span_order, clock, reset, rsp_valid && rsp_row_covered, rsp_span_left <= rsp_span_right)

   // A covered row implies a non-empty box containing the span
   `ASSERT_IMPLIES(a_span_in_box, clock, reset, rsp_valid && rsp_row_covered, rsp_span_right <= rsp_box_max_x && {1'b0, rsp_span_left} >= rsp_box_min_x)

endmodule

bind outline_row_span_mask orsm_checker u_orsm_checker (.*);

/* verif/outline_row_span_mask_tb.sv */
module outline_row_span_mask_tb;

   localparam int COORD_W         = orsm_pkg::COORD_W;
   localparam int DIM_W           = orsm_pkg::DIM_W;
   localparam int CLOCK_HALF      = 2;
   localparam int ITEM_TARGET     = 290;
   // Longest request: a point walk across the whole image
   localparam int BLOCK_LATENCY   = 3200;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 5000000;
   localparam int REPORT_LIMIT    = 10;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   typedef struct packed {
      logic               row_covered;
      logic [COORD_W-1:0] span_left;
      logic [COORD_W-1:0] span_right;
      logic [DIM_W-1:0]   box_min_x;
      logic [DIM_W-1:0]   box_min_y;
      logic [COORD_W-1:0] box_max_x;
      logic [COORD_W-1:0] box_max_y;
      logic               outline_closed;
   } row_span_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func  = orsm_pkg::FUNC_ADD;
   logic [COORD_W-1:0] req_x     = '0;
   logic [COORD_W-1:0] req_y     = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_row_covered;
   logic [COORD_W-1:0] rsp_span_left;
   logic [COORD_W-1:0] rsp_span_right;
   logic [DIM_W-1:0]   rsp_box_min_x;
   logic [DIM_W-1:0]   rsp_box_min_y;
   logic [COORD_W-1:0] rsp_box_max_x;
   logic [COORD_W-1:0] rsp_box_max_y;
   logic               rsp_outline_closed;
   logic               csr_wr_en   = 1'b0;
   logic               csr_index   = orsm_pkg::CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]   csr_wr_data = '0;

   outline_row_span_mask i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_x              (req_x),
      .req_y              (req_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_row_covered    (rsp_row_covered),
      .rsp_span_left      (rsp_span_left),
      .rsp_span_right     (rsp_span_right),
      .rsp_box_min_x      (rsp_box_min_x),
      .rsp_box_min_y      (rsp_box_min_y),
      .rsp_box_max_x      (rsp_box_max_x),
      .rsp_box_max_y      (rsp_box_max_y),
      .rsp_outline_closed (rsp_outline_closed),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Shadow of the outline state
   logic [DIM_W-1:0]   img_w_reg = orsm_pkg::DIM_RESET;
   logic [DIM_W-1:0]   img_h_reg = orsm_pkg::DIM_RESET;
   logic [COORD_W-1:0] span_lo [orsm_pkg::DEF_MAX_HEIGHT];
   logic [COORD_W-1:0] span_hi [orsm_pkg::DEF_MAX_HEIGHT];
   logic               row_hit [orsm_pkg::DEF_MAX_HEIGHT];
   int                 pen_x, pen_y, anchor_x, anchor_y;
   logic [DIM_W-1:0]   box_x0, box_y0;
   logic [COORD_W-1:0] box_x1, box_y1;
   logic               pen_down, shape_closed;

   row_span_type       expected_spans [$];
   int                 requests_sent  = 0;
   int                 mismatch_count = 0;
   int                 burst_left     = 0;
   int                 holds_asked    = 0;
   int                 holds_seen     = 0;
   int                 hold_left      = 0;
   int                 mode_left      = 0;
   rx_mode_type        rx_mode        = RX_STEADY;
   int                 cycle_count    = 0;
   row_span_type       got_span, want_span;

   // Register value saturated into 1..maxv
   function automatic int clip_dim(input logic [DIM_W-1:0] v, input int maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   task automatic restart_shape();
      foreach (row_hit[r]) row_hit[r] = 1'b0;
      pen_x = 0;
      pen_y = 0;
      anchor_x = 0;
      anchor_y = 0;
      box_x0 = DIM_W'(clip_dim(img_w_reg, orsm_pkg::DEF_MAX_WIDTH));
      box_y0 = DIM_W'(clip_dim(img_h_reg, orsm_pkg::DEF_MAX_HEIGHT));
      box_x1 = '0;
      box_y1 = '0;
      pen_down = 1'b0;
      shape_closed = 1'b0;
   endtask

   task automatic plot_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      if (!row_hit[py]) begin
         row_hit[py] = 1'b1;
         span_lo[py] = px;
         span_hi[py] = px;
      end else if (px < span_lo[py]) begin
         span_lo[py] = px;
      end else if (px > span_hi[py]) begin
         span_hi[py] = px;
      end
      if ({1'b0, px} < box_x0) box_x0 = {1'b0, px};
      if (px > box_x1) box_x1 = px;
      if ({1'b0, py} < box_y0) box_y0 = {1'b0, py};
      if (py > box_y1) box_y1 = py;
   endtask

   // 8-connected walk, marking every pixel strictly between the two ends
   task automatic trace_gap(input int ax, input int ay, input int bx, input int by);
      while (bx - ax > 1 || ax - bx > 1 || by - ay > 1 || ay - by > 1) begin
         ax += (bx > ax) ? 1 : ((bx < ax) ? -1 : 0);
         ay += (by > ay) ? 1 : ((by < ay) ? -1 : 0);
         plot_pixel(COORD_W'(ax), COORD_W'(ay));
      end
   endtask

   // Update the outline for one accepted request; reads queue their reply
   task automatic predict_request(input orsm_pkg::func_type f,
                                  input logic [COORD_W-1:0] xv,
                                  input logic [COORD_W-1:0] yv);
      int           w, h, cx, cy;
      row_span_type reply;
      w = clip_dim(img_w_reg, orsm_pkg::DEF_MAX_WIDTH);
      h = clip_dim(img_h_reg, orsm_pkg::DEF_MAX_HEIGHT);
      case (f)
         orsm_pkg::FUNC_ADD: begin
            if (!shape_closed) begin
               cx = (int'(xv) > w - 1) ? w - 1 : int'(xv);
               cy = (int'(yv) > h - 1) ? h - 1 : int'(yv);
               if (!pen_down) begin
                  anchor_x = cx;
                  anchor_y = cy;
                  pen_down = 1'b1;
               end else begin
                  trace_gap(pen_x, pen_y, cx, cy);
               end
               plot_pixel(COORD_W'(cx), COORD_W'(cy));
               pen_x = cx;
               pen_y = cy;
            end
         end
         orsm_pkg::FUNC_CLOSE: begin
            if (pen_down && !shape_closed) begin
               trace_gap(pen_x, pen_y, anchor_x, anchor_y);
               pen_x = anchor_x;
               pen_y = anchor_y;
               shape_closed = 1'b1;
            end
         end
         orsm_pkg::FUNC_START: begin
            restart_shape();
         end
         default: begin
            reply.row_covered    = row_hit[yv];
            reply.span_left      = row_hit[yv] ? span_lo[yv] : '0;
            reply.span_right     = row_hit[yv] ? span_hi[yv] : '0;
            reply.box_min_x      = box_x0;
            reply.box_min_y      = box_y0;
            reply.box_max_x      = box_x1;
            reply.box_max_y      = box_y1;
            reply.outline_closed = shape_closed;
            expected_spans.push_back(reply);
         end
      endcase
   endtask

   initial restart_shape();

   // Offer one request and hold it until taken; valid is left high on return
   task automatic send_request(input orsm_pkg::func_type f, input logic [COORD_W-1:0] xv,
                               input logic [COORD_W-1:0] yv);
      req_valid <= 1'b1;
      req_func  <= f;
      req_x     <= xv;
      req_y     <= yv;
      do @(posedge clock); while (!req_ready);
      predict_request(f, xv, yv);
      requests_sent++;
   endtask

   // Bursts of back-to-back requests separated by random gaps
   task automatic offer_request(input orsm_pkg::func_type f, input logic [COORD_W-1:0] xv,
                                input logic [COORD_W-1:0] yv);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(f, xv, yv);
   endtask

   // Valid drops, then wait for every reply
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_spans.size() != 0);
   endtask

   // All replies in, then room for a trailing point walk or clear to finish
   task automatic settle_block();
      drain_replies();
      repeat (BLOCK_LATENCY) @(posedge clock);
   endtask

   task automatic write_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_index   <= orsm_pkg::CSR_IMAGE_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      img_w_reg = w;
      csr_index   <= orsm_pkg::CSR_IMAGE_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      img_h_reg = h;
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return DIM_W'($urandom_range(1, 8));
         3:       return orsm_pkg::DIM_RESET;
         4:       return DIM_W'($urandom);
         default: return DIM_W'($urandom_range(16, 1023));
      endcase
   endfunction

   // Rows near the outline most of the time, anywhere otherwise
   function automatic logic [COORD_W-1:0] pick_row();
      int lo, hi;
      if (pen_down && $urandom_range(0, 3) != 0) begin
         lo = (int'(box_y0) > 2) ? int'(box_y0) - 2 : 0;
         hi = (int'(box_y1) + 2 > 1023) ? 1023 : int'(box_y1) + 2;
         return COORD_W'($urandom_range(hi, lo));
      end
      return COORD_W'($urandom);
   endfunction

   // Freehand pointer motion: mostly short moves, some swings, rare jumps
   task automatic pick_point(output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
      int mode, nx, ny;
      mode = $urandom_range(0, 19);
      if (mode == 0 || (!pen_down && mode < 10)) begin
         nx = int'(COORD_W'($urandom));
         ny = int'(COORD_W'($urandom));
      end else if (!pen_down) begin
         nx = $urandom_range(0, clip_dim(img_w_reg, orsm_pkg::DEF_MAX_WIDTH) + 4);
         ny = $urandom_range(0, clip_dim(img_h_reg, orsm_pkg::DEF_MAX_HEIGHT) + 4);
      end else if (mode == 1) begin
         nx = pen_x + $urandom_range(0, 120) - 60;
         ny = pen_y + $urandom_range(0, 120) - 60;
      end else begin
         nx = pen_x + $urandom_range(0, 8) - 4;
         ny = pen_y + $urandom_range(0, 8) - 4;
      end
      px = COORD_W'((nx < 0) ? 0 : ((nx > 1023) ? 1023 : nx));
      py = COORD_W'((ny < 0) ? 0 : ((ny > 1023) ? 1023 : ny));
   endtask

   // Empty outline, edge-to-edge walks, close handling, restart
   task automatic test_directed_extremes();
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_CLOSE, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1,    10'd1);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd1023);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd0,    10'd5);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd1023);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd512);
      offer_request(orsm_pkg::FUNC_READ,  10'd1023, 10'd3);
      offer_request(orsm_pkg::FUNC_CLOSE, 10'd1023, 10'd1023);
      offer_request(orsm_pkg::FUNC_CLOSE, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd600,  10'd600);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd600);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd1);
      offer_request(orsm_pkg::FUNC_START, 10'd1023, 10'd1023);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd0,    10'd1023);
      offer_request(orsm_pkg::FUNC_CLOSE, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd512);
   endtask

   // Saturated and tiny image sizes, and a size change mid-outline
   task automatic test_image_size_limits();
      write_image_size('0, '1);
      offer_request(orsm_pkg::FUNC_START, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd500,  10'd700);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd1023);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd700);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd1023);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      write_image_size('1, '0);
      offer_request(orsm_pkg::FUNC_START, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd300,  10'd900);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd5);
      offer_request(orsm_pkg::FUNC_CLOSE, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      write_image_size(11'd1, 11'd1);
      offer_request(orsm_pkg::FUNC_START, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd1023);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      // New size applies to later points, box kept until the next start
      write_image_size(11'd37, 11'd100);
      offer_request(orsm_pkg::FUNC_ADD,   10'd1023, 10'd1023);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd99);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd0);
      write_image_size(orsm_pkg::DIM_RESET, orsm_pkg::DIM_RESET);
      offer_request(orsm_pkg::FUNC_START, 10'd0,    10'd0);
      offer_request(orsm_pkg::FUNC_READ,  10'd0,    10'd5);
   endtask

   // Long receiver hold while reads keep coming, then a full drain
   task automatic test_reply_backpressure();
      logic [COORD_W-1:0] px, py;
      offer_request(orsm_pkg::FUNC_START, COORD_W'($urandom), COORD_W'($urandom));
      repeat (4) begin
         pick_point(px, py);
         offer_request(orsm_pkg::FUNC_ADD, px, py);
      end
      drain_replies();
      holds_asked++;
      repeat (16) send_request(orsm_pkg::FUNC_READ, COORD_W'($urandom), pick_row());
      pick_point(px, py);
      send_request(orsm_pkg::FUNC_ADD, px, py);
      send_request(orsm_pkg::FUNC_READ, COORD_W'($urandom), pick_row());
      drain_replies();
   endtask

   // Random outlines with random content, broken sequences and noise
   task automatic test_random_outlines();
      logic [COORD_W-1:0] px, py;
      int                 n;
      while (requests_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) write_image_size(pick_dim(), pick_dim());
         if ($urandom_range(0, 5) != 0)
            offer_request(orsm_pkg::FUNC_START, COORD_W'($urandom), COORD_W'($urandom));
         n = $urandom_range(2, 14);
         repeat (n) begin
            pick_point(px, py);
            offer_request(orsm_pkg::FUNC_ADD, px, py);
            if ($urandom_range(0, 9) == 0)
               offer_request(orsm_pkg::FUNC_READ, COORD_W'($urandom), pick_row());
         end
         if ($urandom_range(0, 9) < 8)
            offer_request(orsm_pkg::FUNC_CLOSE, COORD_W'($urandom), COORD_W'($urandom));
         n = $urandom_range(2, 6);
         repeat (n) offer_request(orsm_pkg::FUNC_READ, COORD_W'($urandom), pick_row());
         n = $urandom_range(0, 2);
         repeat (n) begin
            offer_request(orsm_pkg::func_type'($urandom_range(0, 3)), COORD_W'($urandom),
                          COORD_W'($urandom));
         end
      end
   endtask

   // Receiver: long holds on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_seen != holds_asked) begin
         holds_seen <= holds_asked;
         hold_left  <= RSP_HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   <= rx_mode_type'($urandom_range(0, 2));
            mode_left <= $urandom_range(50, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Reply checker against the oldest pending row read
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_span.row_covered    = rsp_row_covered;
         got_span.span_left      = rsp_span_left;
         got_span.span_right     = rsp_span_right;
         got_span.box_min_x      = rsp_box_min_x;
         got_span.box_min_y      = rsp_box_min_y;
         got_span.box_max_x      = rsp_box_max_x;
         got_span.box_max_y      = rsp_box_max_y;
         got_span.outline_closed = rsp_outline_closed;
         if (expected_spans.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected row reply at cycle %0d", cycle_count);
         end else begin
            want_span = expected_spans.pop_front();
            if (got_span !== want_span) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("row reply mismatch at cycle %0d", cycle_count);
                  $display("  exp cov %0d span %0d..%0d box (%0d,%0d)-(%0d,%0d) closed %0d",
                           want_span.row_covered, want_span.span_left,
                           want_span.span_right, want_span.box_min_x,
                           want_span.box_min_y, want_span.box_max_x,
                           want_span.box_max_y, want_span.outline_closed);
                  $display("  got cov %0d span %0d..%0d box (%0d,%0d)-(%0d,%0d) closed %0d",
                           got_span.row_covered, got_span.span_left,
                           got_span.span_right, got_span.box_min_x,
                           got_span.box_min_y, got_span.box_max_x,
                           got_span.box_max_y, got_span.outline_closed);
               end
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("outline_row_span_mask_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Span memory clear after reset
      do @(posedge clock); while (!req_ready);
      test_directed_extremes();
      test_image_size_limits();
      test_reply_backpressure();
      test_random_outlines();
      settle_block();
      if (mismatch_count == 0 && expected_spans.size() == 0) begin
         $display("outline_row_span_mask_tb: PASS");
      end else begin
         $display("outline_row_span_mask_tb: FAIL");
      end
      $finish;
   end

endmodule
